@@ rtl/kec_pkg.sv @@
// ----------------------------------------------------------------------------
// kec_pkg
// Shared types and constants of the keyed event coalescer: payload structs,
// item kind codes, register indexes, controller states and the command and
// status groups between controller and datapath.
// ----------------------------------------------------------------------------
package kec_pkg;

	localparam int TIME_W     = 40;
	localparam int MAG_W      = 16;
	localparam int TOTAL_W    = 17;
	localparam int KEY_W      = 4;
	localparam int THRESH_W   = 16;
	localparam int WINDOW_W   = 20;
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 20;

	localparam logic [THRESH_W-1:0] THRESHOLD_RESET = 16'd30;
	localparam logic [WINDOW_W-1:0] WINDOW_RESET    = 20'd5000;

	typedef enum logic [1:0] {
		KIND_EVENT = 2'd0,
		KIND_PASS  = 2'd1,
		KIND_TICK  = 2'd2,
		KIND_CLEAR = 2'd3
	} kec_kind_t;

	typedef enum logic {
		OUT_PASS  = 1'b0,
		OUT_BATCH = 1'b1
	} kec_okind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BATCH_THRESHOLD = 4'd0,
		REG_WINDOW_MS       = 4'd1
	} kec_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_SCAN,
		ST_UPD_RD,
		ST_UPD,
		ST_FIN
	} kec_state_t;

	typedef struct packed {
		logic [1:0]        kind;
		logic [KEY_W-1:0]  key_id;
		logic [MAG_W-1:0]  magnitude;
		logic [TIME_W-1:0] observed_ms;
		logic [TIME_W-1:0] source_ms;
	} kec_in_t;

	typedef struct packed {
		logic               out_kind;
		logic [KEY_W-1:0]   out_key;
		logic [TOTAL_W-1:0] out_total;
		logic [TIME_W-1:0]  out_time_ms;
		logic               last;
	} kec_out_t;

	typedef struct packed {
		logic [TIME_W-1:0]  window_start;
		logic [TIME_W-1:0]  last_source;
		logic [TOTAL_W-1:0] total;
	} kec_entry_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;      // capture the accepted item, rewind the scan index
		logic clear;     // empty the table
		logic rd_scan;   // read the entry at the scan index
		logic scan_act;  // act on the scanned entry and step to the next one
		logic rd_key;    // read the entry of the item's key
		logic upd_act;   // open or extend the item's entry
		logic pass_act;  // emit the pass-through result
		logic fin_act;   // release the held result as the item's last one
	} kec_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic [1:0] kind;
		logic       now_nz;
		logic       key_ok;
		logic       idx_last;
		logic       scan_emit;
		logic       upd_emit;
		logic       hold_v;
		logic       out_free;
		logic       slot_ok;
	} kec_sts_t;

endpackage

@@ rtl/kec_ctrl.sv @@
// ----------------------------------------------------------------------------
// kec_ctrl
// Sequencer of the coalescer: accepts an item, runs the expiry scan over the
// table, updates the item's entry and closes the item's result stream.
// ----------------------------------------------------------------------------
module kec_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	output kec_pkg::kec_cmd_t cmd,
	input  kec_pkg::kec_sts_t sts
);

	kec_pkg::kec_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= kec_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			kec_pkg::ST_IDLE: begin
				if (item_valid) begin
					state_d = kec_pkg::ST_DECODE;
				end
			end
			kec_pkg::ST_DECODE: begin
				if (sts.kind == kec_pkg::KIND_CLEAR) begin
					state_d = kec_pkg::ST_IDLE;
				end else if (sts.now_nz) begin
					state_d = kec_pkg::ST_SCAN;
				end else begin
					state_d = kec_pkg::ST_UPD_RD;
				end
			end
			kec_pkg::ST_SCAN: begin
				if (!(sts.scan_emit && !sts.slot_ok) && sts.idx_last) begin
					state_d = kec_pkg::ST_UPD_RD;
				end
			end
			kec_pkg::ST_UPD_RD: begin
				if (sts.kind == kec_pkg::KIND_EVENT && sts.key_ok) begin
					state_d = kec_pkg::ST_UPD;
				end else if (sts.kind == kec_pkg::KIND_PASS) begin
					if (sts.slot_ok) begin
						state_d = kec_pkg::ST_FIN;
					end
				end else begin
					state_d = kec_pkg::ST_FIN;
				end
			end
			kec_pkg::ST_UPD: begin
				if (!(sts.upd_emit && !sts.slot_ok)) begin
					state_d = kec_pkg::ST_FIN;
				end
			end
			kec_pkg::ST_FIN: begin
				if (!sts.hold_v || sts.out_free) begin
					state_d = kec_pkg::ST_IDLE;
				end
			end
			default: state_d = kec_pkg::ST_IDLE;
		endcase
	end

	// Outputs.
	always_comb begin
		cmd        = '0;
		item_ready = 1'b0;
		unique case (state_q)
			kec_pkg::ST_IDLE: begin
				item_ready = 1'b1;
				cmd.load   = item_valid;
			end
			kec_pkg::ST_DECODE: begin
				if (sts.kind == kec_pkg::KIND_CLEAR) begin
					cmd.clear = 1'b1;
				end else if (sts.now_nz) begin
					cmd.rd_scan = 1'b1;
				end
			end
			kec_pkg::ST_SCAN: begin
				cmd.scan_act = !(sts.scan_emit && !sts.slot_ok);
			end
			kec_pkg::ST_UPD_RD: begin
				if (sts.kind == kec_pkg::KIND_EVENT && sts.key_ok) begin
					cmd.rd_key = 1'b1;
				end else if (sts.kind == kec_pkg::KIND_PASS) begin
					cmd.pass_act = sts.slot_ok;
				end
			end
			kec_pkg::ST_UPD: begin
				cmd.upd_act = !(sts.upd_emit && !sts.slot_ok);
			end
			kec_pkg::ST_FIN: begin
				cmd.fin_act = sts.hold_v && sts.out_free;
			end
			default: cmd = '0;
		endcase
	end

endmodule

@@ rtl/kec_dp.sv @@
// ----------------------------------------------------------------------------
// kec_dp
// Datapath of the coalescer: configuration registers, the entry table with
// its occupancy bits, expiry and update arithmetic, and the two-deep result
// stage that marks the last result of each item.
// ----------------------------------------------------------------------------
module kec_dp #(
	parameter int NUM_KEYS = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  kec_pkg::kec_in_t                     item,
	input  logic                                 cfg_valid,
	input  logic [kec_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [kec_pkg::CFG_DATA_W-1:0]       cfg_data,
	output logic                                 result_valid,
	input  logic                                 result_ready,
	output kec_pkg::kec_out_t                    result,
	input  kec_pkg::kec_cmd_t                    cmd,
	output kec_pkg::kec_sts_t                    sts
);

	localparam int KW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

	logic [kec_pkg::THRESH_W-1:0] threshold_q;
	logic [kec_pkg::WINDOW_W-1:0] window_q;
	kec_pkg::kec_in_t             item_q;
	logic [kec_pkg::TIME_W-1:0]   now_q;
	logic [KW-1:0]                idx_q;
	logic [NUM_KEYS-1:0]          occ_q;
	kec_pkg::kec_entry_t          mem_q [NUM_KEYS];
	kec_pkg::kec_entry_t          rdata_q;
	kec_pkg::kec_out_t            hold_q, out_q;
	logic                         hold_v_q, out_v_q;

	// Configuration writes; indexes beyond the list are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= kec_pkg::THRESHOLD_RESET;
			window_q    <= kec_pkg::WINDOW_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				kec_pkg::REG_BATCH_THRESHOLD: threshold_q <= cfg_data[kec_pkg::THRESH_W-1:0];
				kec_pkg::REG_WINDOW_MS:       window_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// Item capture. The resolved time falls back to the source time.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= item;
			now_q  <= (item.observed_ms != '0) ? item.observed_ms : item.source_ms;
		end
	end

	logic          idx_last;
	logic [KW-1:0] kidx;
	logic          key_ok;

	assign idx_last = (idx_q == KW'(NUM_KEYS - 1));
	assign kidx     = KW'(item_q.key_id);
	assign key_ok   = (32'(item_q.key_id) < NUM_KEYS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (cmd.load) begin
			idx_q <= '0;
		end else if (cmd.scan_act && !idx_last) begin
			idx_q <= idx_q + 1'b1;
		end
	end

	// Expiry test of the scanned entry.
	logic [kec_pkg::TIME_W:0] age;
	logic                     expire, scan_emit;

	assign age       = {1'b0, now_q} - {1'b0, rdata_q.window_start};
	assign expire    = occ_q[idx_q] && (rdata_q.window_start != '0) && !age[kec_pkg::TIME_W]
		&& (age[kec_pkg::TIME_W-1:0] >= {{(kec_pkg::TIME_W-kec_pkg::WINDOW_W){1'b0}}, window_q});
	assign scan_emit = expire && (rdata_q.total != '0);

	// Open or extend the item's entry.
	logic [kec_pkg::MAG_W-1:0]   mag_eff;
	logic                        open_e, upd_flush, upd_emit;
	logic [kec_pkg::TOTAL_W-1:0] new_total;
	kec_pkg::kec_entry_t         new_entry;

	assign mag_eff   = (item_q.magnitude != '0) ? item_q.magnitude : kec_pkg::MAG_W'(1);
	assign open_e    = !occ_q[kidx] || (rdata_q.window_start == '0);
	assign new_total = (open_e ? '0 : rdata_q.total) + kec_pkg::TOTAL_W'(mag_eff);
	assign upd_flush = (new_total >= kec_pkg::TOTAL_W'(threshold_q));
	assign upd_emit  = upd_flush && (new_total != '0);

	always_comb begin
		new_entry.total = new_total;
		if (open_e) begin
			new_entry.window_start = now_q;
			new_entry.last_source  = item_q.source_ms;
		end else begin
			new_entry.window_start = rdata_q.window_start;
			new_entry.last_source  = (item_q.source_ms != '0) ? item_q.source_ms
				: rdata_q.last_source;
		end
	end

	// Entry table: one read port with registered data, one write port.
	logic          rd_en;
	logic [KW-1:0] raddr;

	assign rd_en = cmd.rd_key || cmd.rd_scan || (cmd.scan_act && !idx_last);
	always_comb begin
		if (cmd.rd_key) begin
			raddr = kidx;
		end else if (cmd.scan_act) begin
			raddr = idx_q + 1'b1;
		end else begin
			raddr = idx_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.upd_act) begin
			mem_q[kidx] <= new_entry;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rdata_q <= mem_q[raddr];
		end
	end

	// Occupancy bits double as the table's valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
		end else if (cmd.clear) begin
			occ_q <= '0;
		end else if (cmd.scan_act && expire) begin
			occ_q[idx_q] <= 1'b0;
		end else if (cmd.upd_act) begin
			occ_q[kidx] <= !upd_flush;
		end
	end

	// New result of this cycle.
	logic              produce;
	kec_pkg::kec_out_t new_res;

	assign produce = (cmd.scan_act && scan_emit) || (cmd.upd_act && upd_emit) || cmd.pass_act;

	always_comb begin
		new_res.last = 1'b0;
		if (cmd.pass_act) begin
			new_res.out_kind    = kec_pkg::OUT_PASS;
			new_res.out_key     = item_q.key_id;
			new_res.out_total   = kec_pkg::TOTAL_W'(item_q.magnitude);
			new_res.out_time_ms = item_q.source_ms;
		end else if (cmd.upd_act) begin
			new_res.out_kind    = kec_pkg::OUT_BATCH;
			new_res.out_key     = item_q.key_id;
			new_res.out_total   = new_total;
			new_res.out_time_ms = new_entry.last_source;
		end else begin
			new_res.out_kind    = kec_pkg::OUT_BATCH;
			new_res.out_key     = kec_pkg::KEY_W'(idx_q);
			new_res.out_total   = rdata_q.total;
			new_res.out_time_ms = rdata_q.last_source;
		end
	end

	// A result waits in the hold stage until the next one, or the end of the
	// item, tells whether it is the last.
	logic              out_free, push;
	kec_pkg::kec_out_t push_res;

	assign out_free = !out_v_q || result_ready;
	assign push     = (produce && hold_v_q) || cmd.fin_act;

	always_comb begin
		push_res      = hold_q;
		push_res.last = cmd.fin_act;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if (produce) begin
				hold_v_q <= 1'b1;
			end else if (cmd.fin_act) begin
				hold_v_q <= 1'b0;
			end
			out_v_q <= push || (out_v_q && !result_ready);
		end
	end

	always_ff @(posedge clk) begin
		if (produce) begin
			hold_q <= new_res;
		end
		if (push) begin
			out_q <= push_res;
		end
	end

	assign result_valid = out_v_q;
	assign result       = out_q;

	always_comb begin
		sts.kind      = item_q.kind;
		sts.now_nz    = (now_q != '0);
		sts.key_ok    = key_ok;
		sts.idx_last  = idx_last;
		sts.scan_emit = scan_emit;
		sts.upd_emit  = upd_emit;
		sts.hold_v    = hold_v_q;
		sts.out_free  = out_free;
		sts.slot_ok   = !hold_v_q || out_free;
	end

endmodule

@@ rtl/keyed_event_coalescer_unit.sv @@
// ----------------------------------------------------------------------------
// keyed_event_coalescer_unit
// Per-key coalescing table: sums event magnitudes per key, flushes batches on
// age or on reaching a threshold, and passes other events straight through.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake                    Beat
//  item     in         item_valid / item_ready      kec_in_t: kind, key, magnitude, times
//  result   out        result_valid / result_ready  kec_out_t: one batch or passed event
//  cfg      in         cfg_valid / cfg_ready        cfg_index, cfg_data (register write)
//
// An item beat is taken in the idle state only; the unit works on one item at a
// time. A coalescable event with a nonzero resolved time first passes the expiry
// scan, which reads one table entry per cycle through the single read port of
// the table while the result channel does not stall. Pass-through and tick items
// go through the scan too but update no entry; with a zero resolved time the scan
// is skipped, and a clear item only empties the table.
// Result beats leave through an output register; a result waits in a
// hold stage so that the last flag can be set on the final beat of an item.
// A stalled result channel freezes the scan or update until a slot is free.
// Reset clears the occupancy bits at once, so there is no clearing pass; the
// registers return to a threshold of 30 and a window of 5000 ms.
// cfg_ready is always high; writes are meant for times when the unit is idle.
//
module keyed_event_coalescer_unit #(
	parameter int NUM_KEYS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           item_valid,
	output logic                           item_ready,
	input  kec_pkg::kec_in_t               item,
	output logic                           result_valid,
	input  logic                           result_ready,
	output kec_pkg::kec_out_t              result,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [kec_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [kec_pkg::CFG_DATA_W-1:0] cfg_data
);

	kec_pkg::kec_cmd_t cmd;
	kec_pkg::kec_sts_t sts;

	// Register writes never wait.
	assign cfg_ready = 1'b1;

	// The controller sequences the accept, the scan, the update and the
	// closing of the result stream.
	kec_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.cmd        (cmd),
		.sts        (sts)
	);

	// The datapath holds the table, the registers and the result stages.
	kec_dp #(
		.NUM_KEYS (NUM_KEYS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.cfg_valid    (cfg_valid),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.cmd          (cmd),
		.sts          (sts)
	);

`ifndef SYNTHESIS
	// Every result of the previous item has left the hold stage before a new
	// item is taken.
	a_hold_empty_at_accept: assert property (@(posedge clk) disable iff (!arst_n)
		item_ready |-> !sts.hold_v)
		else $error("hold stage busy while a new item can be taken");

	// The scan only advances over a flushing entry when its result has a slot.
	a_scan_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.scan_act && sts.scan_emit) |-> sts.slot_ok)
		else $error("scan result produced without a free slot");

	// Clearing the table produces no result in the same cycle.
	a_clear_silent: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clear |-> !(cmd.scan_act || cmd.upd_act || cmd.pass_act || cmd.fin_act))
		else $error("result produced while clearing the table");

	// An accepted item closes the input until its work is done.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && item_ready) |=> !item_ready)
		else $error("second item taken before the first was processed");
`endif

endmodule
